[rtl/sstf_disk_request_scheduler_top_assert.svh]
// Assertion macros for the shortest-seek-time-first scheduler top level.
// Included by sstf_disk_request_scheduler_top.sv; depends on nothing else.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_TOP_ASSERT_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTF_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSTF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sstf_pkg.sv]
// Shared types and constants of the shortest-seek-time-first scheduler.
// Used by sstf_scan_unit, sstf_disk_request_scheduler_top and the testbench; no dependencies.
package sstf_pkg;

    localparam int TRACK_W   = 10;
    localparam int ID_W      = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUESTER_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] QUEUE_LIMIT_RESET     = 6'd32;
    localparam logic [CFG_W-1:0] REQUESTER_COUNT_RESET = 6'd32;

    typedef enum logic {
        CMD_SUBMIT = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_QUEUED   = 2'd2,
        STATUS_REFUSED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PICK,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ID_W-1:0]     requester_id;
        logic [TRACK_W-1:0]  track;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic                served;
        logic [ID_W-1:0]     served_requester;
        logic [TRACK_W-1:0]  served_track;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]     owner;
        logic [TRACK_W-1:0]  track;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic owner_chk;
    } scan_ctl_t;

    typedef struct packed {
        logic                match;
        logic                have_best;
        logic [ID_W-1:0]     best_owner;
        logic [TRACK_W-1:0]  best_track;
    } scan_res_t;

endpackage

[rtl/sstf_disk_request_scheduler_top.sv]
// Top level of the shortest-seek-time-first disk request scheduler.
// Depends on sstf_pkg, sstf_scan_unit and sstf_disk_request_scheduler_top_assert.svh.
//
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      sstf_pkg::in_item_t s_data
// m_        out        m_valid / m_ready      sstf_pkg::out_item_t m_data
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// A transaction scans every queued entry and, when an entry is served, moves the entries
// behind it down one slot; the queue memory has one read port and both the nearest-track
// scan and the removal move one slot per cycle.
// Reset is synchronous; it empties the queue and sets the head to track 0.
// The input is not ready while a transaction is in work; a stalled result only holds
// the block in its final state until the result register is free.

`include "sstf_disk_request_scheduler_top_assert.svh"

module sstf_disk_request_scheduler_top #(
    parameter int QUEUE_DEPTH    = 32,
    parameter int MAX_REQUESTERS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sstf_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sstf_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sstf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sstf_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LIV_W = $clog2(MAX_REQUESTERS + 1);
    localparam int CMP_W = 10;

    function automatic logic is_full(input logic [CNT_W-1:0] c,
                                     input logic [LIV_W-1:0] l,
                                     input logic [sstf_pkg::CFG_W-1:0] q);
        return (CMP_W'(c) >= CMP_W'(q)) || (CMP_W'(c) >= CMP_W'(l)) ||
               (CMP_W'(c) >= CMP_W'(QUEUE_DEPTH));
    endfunction

    function automatic logic [LIV_W-1:0] load_living(input logic [sstf_pkg::CFG_W-1:0] v);
        return (CMP_W'(v) > CMP_W'(MAX_REQUESTERS)) ? LIV_W'(MAX_REQUESTERS) : LIV_W'(v);
    endfunction

    sstf_pkg::state_t               state_reg, state_next;
    sstf_pkg::in_item_t             item_reg, item_next;
    logic                           full_before_reg, full_before_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [LIV_W-1:0]               living_reg, living_next;
    logic [sstf_pkg::CFG_W-1:0]     limit_reg, limit_next;
    logic [sstf_pkg::TRACK_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]               scan_idx_reg, scan_idx_next;
    logic                           q_valid_reg, q_valid_next;
    logic [CNT_W-1:0]               q_idx_reg, q_idx_next;
    sstf_pkg::out_item_t            res_reg, res_next;
    logic                           m_valid_reg, m_valid_next;
    sstf_pkg::out_item_t            m_data_reg, m_data_next;

    sstf_pkg::entry_t               mem [QUEUE_DEPTH];
    sstf_pkg::entry_t               mem_q_reg;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    sstf_pkg::entry_t               mem_wdata;
    logic [IDX_W-1:0]               mem_raddr;
    logic [CNT_W-1:0]               shift_dst;

    sstf_pkg::scan_ctl_t            scan_ctl;
    sstf_pkg::entry_t               scan_entry;
    logic [CNT_W-1:0]               scan_entry_idx;
    sstf_pkg::scan_res_t            scan_res;
    logic [CNT_W-1:0]               best_idx;
    sstf_pkg::status_t              status;
    logic                           serve;

    sstf_scan_unit #(
        .CNT_W (CNT_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .entry     (scan_entry),
        .entry_idx (scan_entry_idx),
        .head      (head_reg),
        .who       (item_reg.requester_id),
        .res       (scan_res),
        .best_idx  (best_idx)
    );

    assign mem_raddr = scan_idx_reg[IDX_W-1:0];
    assign shift_dst = q_idx_reg - CNT_W'(1);
    assign s_ready   = (state_reg == sstf_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == sstf_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        full_before_next = full_before_reg;
        cnt_next         = cnt_reg;
        living_next      = living_reg;
        limit_next       = limit_reg;
        head_next        = head_reg;
        scan_idx_next    = scan_idx_reg;
        q_valid_next     = q_valid_reg;
        q_idx_next       = q_idx_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg[IDX_W-1:0];
        mem_wdata        = mem_q_reg;
        scan_ctl         = '{clear: 1'b0, sample: 1'b0, owner_chk: 1'b0};
        scan_entry       = mem_q_reg;
        scan_entry_idx   = q_idx_reg;
        status           = sstf_pkg::STATUS_ACCEPTED;
        serve            = 1'b0;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sstf_pkg::CFG_QUEUE_LIMIT: begin
                    limit_next = cfg_wdata;
                end
                sstf_pkg::CFG_REQUESTER_COUNT: begin
                    living_next = load_living(cfg_wdata);
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            sstf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next        = s_data;
                    full_before_next = is_full(cnt_reg, living_reg, limit_reg);
                    scan_idx_next    = '0;
                    q_valid_next     = 1'b0;
                    scan_ctl.clear   = 1'b1;
                    state_next       = sstf_pkg::ST_SCAN;
                end
            end
            sstf_pkg::ST_SCAN: begin
                scan_ctl.sample    = q_valid_reg;
                scan_ctl.owner_chk = 1'b1;
                if (scan_idx_reg < cnt_reg) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    q_valid_next  = 1'b1;
                    q_idx_next    = scan_idx_reg;
                end else begin
                    q_valid_next = 1'b0;
                    if (!q_valid_reg) begin
                        state_next = sstf_pkg::ST_DECIDE;
                    end
                end
            end
            sstf_pkg::ST_DECIDE: begin
                scan_entry     = '{owner: item_reg.requester_id, track: item_reg.track};
                scan_entry_idx = cnt_reg;
                if (item_reg.cmd == sstf_pkg::CMD_SUBMIT) begin
                    if (full_before_reg) begin
                        status = sstf_pkg::STATUS_FULL;
                    end else if (scan_res.match) begin
                        status = sstf_pkg::STATUS_QUEUED;
                    end else begin
                        mem_we          = 1'b1;
                        mem_waddr       = cnt_reg[IDX_W-1:0];
                        mem_wdata       = scan_entry;
                        scan_ctl.sample = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end else begin
                    if (scan_res.match) begin
                        status = sstf_pkg::STATUS_REFUSED;
                    end else if (living_reg != '0) begin
                        living_next = living_reg - LIV_W'(1);
                    end
                end
                res_next = '{status: status, served: 1'b0,
                             served_requester: '0, served_track: '0};
                state_next = sstf_pkg::ST_PICK;
            end
            sstf_pkg::ST_PICK: begin
                serve = is_full(cnt_reg, living_reg, limit_reg) && (cnt_reg != '0);
                if (serve) begin
                    res_next.served           = 1'b1;
                    res_next.served_requester = scan_res.best_owner;
                    res_next.served_track     = scan_res.best_track;
                    head_next                 = scan_res.best_track;
                    scan_idx_next             = best_idx + CNT_W'(1);
                    q_valid_next              = 1'b0;
                    state_next                = sstf_pkg::ST_SHIFT;
                end else begin
                    state_next = sstf_pkg::ST_DONE;
                end
            end
            sstf_pkg::ST_SHIFT: begin
                if (q_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_dst[IDX_W-1:0];
                    mem_wdata = mem_q_reg;
                end
                if (scan_idx_reg < cnt_reg) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    q_valid_next  = 1'b1;
                    q_idx_next    = scan_idx_reg;
                end else begin
                    q_valid_next = 1'b0;
                    if (!q_valid_reg) begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = sstf_pkg::ST_DONE;
                    end
                end
            end
            sstf_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = sstf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sstf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sstf_pkg::ST_IDLE;
            cnt_reg     <= '0;
            living_reg  <= load_living(sstf_pkg::REQUESTER_COUNT_RESET);
            limit_reg   <= sstf_pkg::QUEUE_LIMIT_RESET;
            head_reg    <= '0;
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            living_reg  <= living_next;
            limit_reg   <= limit_next;
            head_reg    <= head_next;
            q_valid_reg <= q_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        full_before_reg <= full_before_next;
        scan_idx_reg    <= scan_idx_next;
        q_idx_reg       <= q_idx_next;
        res_reg         <= res_next;
        m_data_reg      <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    `SSTF_ASSERT_IMPLY(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
    `SSTF_ASSERT_IMPLY(a_pick_has_best, aclk, aresetn, (state_reg == sstf_pkg::ST_PICK) && (cnt_reg != '0), scan_res.have_best, "nonempty queue without a nearest entry")
    `SSTF_ASSERT_IMPLY(a_shift_dst, aclk, aresetn, (state_reg == sstf_pkg::ST_SHIFT) && q_valid_reg, q_idx_reg != '0, "removal copies below slot zero")
    `SSTF_ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_valid && s_ready, state_reg == sstf_pkg::ST_SCAN, "accepted transaction did not start a scan")

endmodule

[rtl/sstf_scan_unit.sv]
// Shared seek-distance and owner-compare unit, fed one queue entry per cycle.
// Depends on sstf_pkg.
module sstf_scan_unit #(
    parameter int CNT_W = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sstf_pkg::scan_ctl_t        ctl,
    input  sstf_pkg::entry_t           entry,
    input  logic [CNT_W-1:0]           entry_idx,
    input  logic [sstf_pkg::TRACK_W-1:0] head,
    input  logic [sstf_pkg::ID_W-1:0]  who,
    output sstf_pkg::scan_res_t        res,
    output logic [CNT_W-1:0]           best_idx
);

    logic                           match_reg, match_next;
    logic                           have_reg, have_next;
    logic [sstf_pkg::TRACK_W-1:0]   dist_reg, dist_next;
    logic [sstf_pkg::TRACK_W-1:0]   btrack_reg, btrack_next;
    logic [sstf_pkg::ID_W-1:0]      bowner_reg, bowner_next;
    logic [CNT_W-1:0]               bidx_reg, bidx_next;
    logic [sstf_pkg::TRACK_W-1:0]   seek_gap;
    logic                           take;

    always_comb begin
        seek_gap = (entry.track >= head) ? (entry.track - head) : (head - entry.track);
        take = ctl.sample && (!have_reg || (seek_gap <= dist_reg));
        match_next  = match_reg;
        have_next   = have_reg;
        dist_next   = dist_reg;
        btrack_next = btrack_reg;
        bowner_next = bowner_reg;
        bidx_next   = bidx_reg;
        if (ctl.clear) begin
            match_next = 1'b0;
            have_next  = 1'b0;
        end else begin
            if (ctl.sample && ctl.owner_chk && (entry.owner == who)) begin
                match_next = 1'b1;
            end
            if (take) begin
                have_next   = 1'b1;
                dist_next   = seek_gap;
                btrack_next = entry.track;
                bowner_next = entry.owner;
                bidx_next   = entry_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
            have_reg  <= 1'b0;
        end else begin
            match_reg <= match_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg   <= dist_next;
        btrack_reg <= btrack_next;
        bowner_reg <= bowner_next;
        bidx_reg   <= bidx_next;
    end

    assign res = '{match: match_reg, have_best: have_reg,
                   best_owner: bowner_reg, best_track: btrack_reg};
    assign best_idx = bidx_reg;

endmodule

[dv/sstf_disk_request_scheduler_top_test.sv]
// Self-checking testbench for the shortest-seek-time-first disk request scheduler.
// Depends on sstf_pkg and sstf_disk_request_scheduler_top; a shadow queue predicts
// every result from the accepted transactions and the register writes.
module sstf_disk_request_scheduler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QDEPTH = 32;
    localparam int unsigned MAXREQ = 32;
    localparam int SETTLE = 2 * QDEPTH + 16;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 205;
    localparam int ID_BITS = sstf_pkg::ID_W;
    localparam int TRACK_BITS = sstf_pkg::TRACK_W;
    localparam int CFG_BITS = sstf_pkg::CFG_W;

    class sstf_shadow;
        logic [sstf_pkg::TRACK_W-1:0] slot_track [QDEPTH];
        logic [sstf_pkg::ID_W-1:0]    slot_owner [QDEPTH];
        int unsigned                  entry_count;
        int unsigned                  head_track;
        int unsigned                  living;
        int unsigned                  queue_limit;
        sstf_pkg::out_item_t          outcome_q [$];
        int unsigned                  mismatches;
        int unsigned                  checked;
        int unsigned                  dispatched;

        function new();
            entry_count = 0;
            head_track  = 0;
            queue_limit = 32'(sstf_pkg::QUEUE_LIMIT_RESET);
            living      = (32'(sstf_pkg::REQUESTER_COUNT_RESET) > MAXREQ) ? MAXREQ
                                                                          : 32'(sstf_pkg::REQUESTER_COUNT_RESET);
            mismatches  = 0;
            checked     = 0;
            dispatched  = 0;
        endfunction

        function void load_reg(logic [sstf_pkg::CFG_IDX_W-1:0] idx,
                               logic [sstf_pkg::CFG_W-1:0] val);
            if (idx == sstf_pkg::CFG_QUEUE_LIMIT) begin
                queue_limit = 32'(val);
            end else begin
                living = (32'(val) > MAXREQ) ? MAXREQ : 32'(val);
            end
        endfunction

        function bit is_full();
            return entry_count >= queue_limit || entry_count >= living || entry_count >= QDEPTH;
        endfunction

        function bit owner_queued(logic [sstf_pkg::ID_W-1:0] who);
            for (int unsigned i = 0; i < entry_count; i++) begin
                if (slot_owner[i] == who) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(sstf_pkg::in_item_t req);
            sstf_pkg::out_item_t res;
            int unsigned         best;
            int unsigned         best_dist;
            int unsigned         seek_gap;
            int unsigned         trk;
            res = '0;
            res.status = sstf_pkg::STATUS_ACCEPTED;
            if (req.cmd == sstf_pkg::CMD_SUBMIT) begin
                if (is_full()) begin
                    res.status = sstf_pkg::STATUS_FULL;
                end else if (owner_queued(req.requester_id)) begin
                    res.status = sstf_pkg::STATUS_QUEUED;
                end else begin
                    slot_track[entry_count] = req.track;
                    slot_owner[entry_count] = req.requester_id;
                    entry_count++;
                end
            end else begin
                if (owner_queued(req.requester_id)) begin
                    res.status = sstf_pkg::STATUS_REFUSED;
                end else if (living > 0) begin
                    living--;
                end
            end
            if (is_full() && entry_count > 0) begin
                best = 0;
                best_dist = 0;
                for (int unsigned i = 0; i < entry_count; i++) begin
                    trk = 32'(slot_track[i]);
                    seek_gap = (trk >= head_track) ? trk - head_track : head_track - trk;
                    if (i == 0 || seek_gap <= best_dist) begin
                        best = i;
                        best_dist = seek_gap;
                    end
                end
                res.served = 1'b1;
                res.served_requester = slot_owner[best];
                res.served_track = slot_track[best];
                head_track = 32'(slot_track[best]);
                for (int unsigned i = best; i + 1 < entry_count; i++) begin
                    slot_track[i] = slot_track[i + 1];
                    slot_owner[i] = slot_owner[i + 1];
                end
                entry_count--;
            end
            outcome_q.push_back(res);
        endfunction

        task flag_mismatch(string what);
            $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(sstf_pkg::out_item_t got);
            sstf_pkg::out_item_t want;
            if (outcome_q.size() == 0) begin
                flag_mismatch("result transaction with no request pending");
                return;
            end
            want = outcome_q.pop_front();
            checked++;
            if (want.served) dispatched++;
            if (got.status !== want.status)
                flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.served !== want.served)
                flag_mismatch($sformatf("served %0d, expected %0d", got.served, want.served));
            if (got.served_requester !== want.served_requester)
                flag_mismatch($sformatf("served_requester %0d, expected %0d",
                                        got.served_requester, want.served_requester));
            if (got.served_track !== want.served_track)
                flag_mismatch($sformatf("served_track %0d, expected %0d",
                                        got.served_track, want.served_track));
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    sstf_pkg::in_item_t             s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    sstf_pkg::out_item_t            m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sstf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sstf_pkg::CFG_W-1:0]     cfg_wdata = '0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned phase_limit [PHASES] = '{32, 8, 32, 1, 63, 0, 20, 3, 16};
    int unsigned phase_count [PHASES] = '{32, 32, 6, 1, 63, 20, 12, 32, 63};

    sstf_shadow shadow = new();

    sstf_disk_request_scheduler_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) shadow.load_reg(cfg_index, cfg_wdata);
            if (s_valid && s_ready) shadow.note_request(s_data);
            if (m_valid && m_ready) shadow.check_result(m_data);
        end
    end

    task automatic push_request(input sstf_pkg::in_item_t req);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue(input sstf_pkg::cmd_t cmd, input int unsigned id,
                         input int unsigned trk);
        sstf_pkg::in_item_t req;
        req.cmd = cmd;
        req.requester_id = ID_BITS'(id);
        req.track = TRACK_BITS'(trk);
        push_request(req);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (shadow.outcome_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [sstf_pkg::CFG_IDX_W-1:0] idx,
                               input logic [sstf_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sstf_pkg::in_item_t random_request();
        sstf_pkg::in_item_t req;
        req.cmd = ($urandom_range(99) < 12) ? sstf_pkg::CMD_FINISH : sstf_pkg::CMD_SUBMIT;
        req.requester_id = ID_BITS'($urandom_range(31));
        case ($urandom_range(9))
            0: req.track = TRACK_BITS'($urandom_range(1023, 1000));
            1, 2: req.track = TRACK_BITS'($urandom_range(15) * 64);
            default: req.track = TRACK_BITS'($urandom_range(999));
        endcase
        return req;
    endfunction

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue(sstf_pkg::CMD_SUBMIT, 0, 0);
        issue(sstf_pkg::CMD_SUBMIT, 31, 1023);
        issue(sstf_pkg::CMD_SUBMIT, 5, 999);
        issue(sstf_pkg::CMD_SUBMIT, 5, 10);
        issue(sstf_pkg::CMD_FINISH, 5, 0);
        issue(sstf_pkg::CMD_FINISH, 7, 0);
        issue(sstf_pkg::CMD_SUBMIT, 7, 500);
        wait_idle();
        program_reg(sstf_pkg::CFG_QUEUE_LIMIT, 6'd2);
        issue(sstf_pkg::CMD_FINISH, 9, 0);
        issue(sstf_pkg::CMD_SUBMIT, 0, 700);
        issue(sstf_pkg::CMD_SUBMIT, 31, 5);
        issue(sstf_pkg::CMD_FINISH, 31, 0);
        wait_idle();
        program_reg(sstf_pkg::CFG_QUEUE_LIMIT, 6'd3);
        issue(sstf_pkg::CMD_SUBMIT, 2, 975);
        issue(sstf_pkg::CMD_SUBMIT, 3, 1023);
        wait_idle();
        program_reg(sstf_pkg::CFG_QUEUE_LIMIT, 6'd0);
        issue(sstf_pkg::CMD_SUBMIT, 4, 1);
        issue(sstf_pkg::CMD_FINISH, 8, 0);
        issue(sstf_pkg::CMD_SUBMIT, 9, 512);
        wait_idle();
        program_reg(sstf_pkg::CFG_REQUESTER_COUNT, 6'd0);
        issue(sstf_pkg::CMD_FINISH, 10, 0);
        wait_idle();
        program_reg(sstf_pkg::CFG_QUEUE_LIMIT, 6'd32);
        program_reg(sstf_pkg::CFG_REQUESTER_COUNT, 6'd1);
        issue(sstf_pkg::CMD_SUBMIT, 11, 300);
        issue(sstf_pkg::CMD_SUBMIT, 12, 1022);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            program_reg(sstf_pkg::CFG_QUEUE_LIMIT, CFG_BITS'(phase_limit[ph]));
            program_reg(sstf_pkg::CFG_REQUESTER_COUNT, CFG_BITS'(phase_count[ph]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    wait_idle();
                    program_reg(sstf_pkg::CFG_REQUESTER_COUNT, CFG_BITS'(phase_count[ph]));
                end
                push_request(random_request());
            end
        end
        wait_idle();

        $display("Checked %0d results, %0d with a dispatched request, across %0d settings.",
                 shadow.checked, shadow.dispatched, PHASES + 6);
        $display("Settings covered zero and saturated registers and all idle and stall mixes.");
        if (shadow.mismatches == 0 && shadow.outcome_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding.", shadow.outcome_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
